// ----- hdl/hsa_pkg.sv -----
// Shared constants, codes and types of the heap segment allocator.
package hsa_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int HEADER_BYTES = 32;
  localparam int ADDR_BITS    = 24;
  localparam int SIZE_W       = 24;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int ACC_W        = 32;
  localparam int STATUS_W     = 3;

  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_REUSED  = 3'd0,
    ST_GROWN   = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_ZERO    = 3'd3,
    ST_FREED   = 3'd4,
    ST_UNKNOWN = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NEXT  = 2'd3
  } fit_t;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic REG_FIT_MODE   = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    SH_NONE   = 2'd0,
    SH_INSERT = 2'd1,
    SH_DELETE = 2'd2
  } shift_t;

  // Command broadcast along the row of cells each cycle.
  typedef struct packed {
    logic   we;
    idx_t   widx;
    size_t  wsize;
    logic   wfree;
    shift_t shift;
    idx_t   sidx;
    size_t  ssize;
    logic   sfree;
  } cell_cmd_t;

endpackage

// ----- hdl/hsa_if.sv -----
// Request and response channel interfaces of the heap segment allocator.
interface hsa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [hsa_pkg::SIZE_W-1:0]  request_size;
  logic [hsa_pkg::SIZE_W-1:0]  block_address;
  modport source (output valid, action, request_size, block_address, input ready);
  modport sink   (input valid, action, request_size, block_address, output ready);
endinterface

interface hsa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [hsa_pkg::ADDR_BITS-1:0] data_address;
  logic [hsa_pkg::STATUS_W-1:0]  status;
  logic                          split_done;
  logic [1:0]                    merges;
  modport source (output valid, data_address, status, split_done, merges, input ready);
  modport sink   (input valid, data_address, status, split_done, merges, output ready);
endinterface

// ----- hdl/hsa_cell.sv -----
// One table entry: payload size and free mark, loaded from a neighbour on a shift.
module hsa_cell (
  input  logic               clk,
  input  hsa_pkg::idx_t      my_index,
  input  hsa_pkg::cell_cmd_t cmd,
  input  hsa_pkg::size_t     left_size,
  input  logic               left_free,
  input  hsa_pkg::size_t     right_size,
  input  logic               right_free,
  output hsa_pkg::size_t     size,
  output logic               free
);
  import hsa_pkg::*;

  always_ff @(posedge clk) begin
    if (cmd.shift == SH_INSERT && my_index > cmd.sidx) begin
      size <= left_size;
      free <= left_free;
    end else if (cmd.shift == SH_INSERT && my_index == cmd.sidx) begin
      size <= cmd.ssize;
      free <= cmd.sfree;
    end else if (cmd.shift == SH_DELETE && my_index >= cmd.sidx) begin
      size <= right_size;
      free <= right_free;
    end else if (cmd.we && my_index == cmd.widx) begin
      size <= cmd.wsize;
      free <= cmd.wfree;
    end
  end

endmodule

// ----- hdl/heap_segment_allocator.sv -----
// Heap segment allocator: a row of segment cells driven by a scanning sequencer.
//
// Channels: req (sink) carries action, request_size and block_address; rsp
// (source) returns data_address, status, split_done and merges, one beat per
// request. cfg_we/cfg_index/cfg_data write fit_mode (index 0) and heap_limit
// (index 1); write only while the block is idle.
// Throughput: one request at a time. An allocate passes through the scan,
// the decision and the response state; a free adds the merge-next and
// merge-prev states, which an unknown address skips. The scan reads one
// cell per cycle while summing the segment addresses.
// A zero-size allocate skips the scan and goes straight to the response state.
// Inserting or removing a segment is one shift of the row: the cells past the
// insert point, or from the delete point on, load from their neighbour at once.
// Reset (synchronous, active high) empties the table, zeroes the heap top,
// drops the rover and restores fit_mode 0 and heap_limit 0xFFFFFF; cell
// contents are left as they are and are never read before written.
// The result beat sits in an output register; a stalled receiver holds it
// there, and the next request is accepted meanwhile but its result waits
// until the register drains.
module heap_segment_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [hsa_pkg::SIZE_W-1:0]  cfg_data,
  hsa_req_if.sink                     req,
  hsa_rsp_if.source                   rsp
);
  import hsa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_DEC   = 6'b000100,
    S_MNEXT = 6'b001000,
    S_MPREV = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t state;

  // Configuration
  fit_t  fit_mode;
  size_t heap_limit;

  // Allocator state
  cnt_t  seg_count;
  size_t heap_top;
  idx_t  rover;
  logic  rover_valid;

  // Request held for the sequencer
  logic                action;
  logic [SIZE_W:0]     want;      // rounded size, may reach 2^24
  size_t               baddr;
  cnt_t                scan_idx;
  cnt_t                start;
  logic [ACC_W-1:0]    acc;

  // Main pick: first/best/worst fit, next-fit wrapped part, or free hit
  logic                found;
  idx_t                pick_idx;
  size_t               pick_size;
  logic [ACC_W-1:0]    pick_addr;
  // Next-fit pick at or after the start point
  logic                found_hi;
  idx_t                hi_idx;
  logic [ACC_W-1:0]    hi_addr;
  size_t               hi_size;

  // Pending result
  logic [ADDR_BITS-1:0] res_addr;
  status_t              res_status;
  logic                 res_split;
  logic [1:0]           res_merges;

  // Row of cells
  size_t     cell_size [MAX_SEGMENTS];
  logic      cell_free [MAX_SEGMENTS];
  cell_cmd_t cmd;

  genvar g;
  generate
    for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
      size_t rsz;
      logic  rfr;
      size_t lsz;
      logic  lfr;
      if (g == MAX_SEGMENTS - 1) begin : g_last
        assign rsz = '0;
        assign rfr = 1'b0;
      end else begin : g_mid
        assign rsz = cell_size[g+1];
        assign rfr = cell_free[g+1];
      end
      if (g == 0) begin : g_first
        assign lsz = '0;
        assign lfr = 1'b0;
      end else begin : g_rest
        assign lsz = cell_size[g-1];
        assign lfr = cell_free[g-1];
      end
      hsa_cell u_cell (
        .clk        (clk),
        .my_index   (IDX_W'(g)),
        .cmd        (cmd),
        .left_size  (lsz),
        .left_free  (lfr),
        .right_size (rsz),
        .right_free (rfr),
        .size       (cell_size[g]),
        .free       (cell_free[g])
      );
    end
  endgenerate

  // Two read ports over the row
  idx_t  pa_idx, pb_idx;
  size_t pa_size, pb_size;
  logic  pa_free, pb_free;
  cnt_t  mi_up;

  assign mi_up  = {1'b0, pick_idx} + cnt_t'(1);
  assign pa_idx = (state == S_SCAN) ? scan_idx[IDX_W-1:0] : pick_idx;
  assign pb_idx = (state == S_MNEXT) ? mi_up[IDX_W-1:0] : pick_idx - idx_t'(1);
  assign pa_size = cell_size[pa_idx];
  assign pa_free = cell_free[pa_idx];
  assign pb_size = cell_size[pb_idx];
  assign pb_free = cell_free[pb_idx];

  // Scan helpers
  logic fits, take_main, take_hi, hit;
  assign fits = pa_free && ({1'b0, pa_size} >= want);
  assign hit  = (acc == {{(ACC_W-SIZE_W){1'b0}}, baddr}) && !pa_free;

  always_comb begin
    take_main = 1'b0;
    take_hi   = 1'b0;
    if (action == ACT_FREE) begin
      take_main = hit && !found;
    end else begin
      unique case (fit_mode)
        FIT_FIRST: take_main = fits && !found;
        FIT_BEST:  take_main = fits && (!found || pa_size < pick_size);
        FIT_WORST: take_main = fits && (!found || pa_size > pick_size);
        FIT_NEXT: begin
          take_hi   = fits && !found_hi && (scan_idx >= start);
          take_main = fits && !found && (scan_idx < start);
        end
        default: take_main = 1'b0;
      endcase
    end
  end

  // Decision helpers
  logic             sel_found;
  idx_t             sel_idx;
  size_t            sel_size;
  logic [ACC_W-1:0] sel_addr;
  logic             do_split;
  logic [SIZE_W+1:0] need;
  cnt_t             sel_up;
  size_t            rest;

  assign sel_found = (fit_mode == FIT_NEXT && found_hi) || found;
  assign sel_idx   = (fit_mode == FIT_NEXT && found_hi) ? hi_idx : pick_idx;
  assign sel_size  = (fit_mode == FIT_NEXT && found_hi) ? hi_size : pick_size;
  assign sel_addr  = (fit_mode == FIT_NEXT && found_hi) ? hi_addr : pick_addr;
  assign sel_up    = {1'b0, sel_idx} + cnt_t'(1);
  assign do_split  = ({2'b0, sel_size} > ({1'b0, want} + (SIZE_W+2)'(HEADER_BYTES + 4)))
                     && (seg_count < cnt_t'(MAX_SEGMENTS));
  assign rest      = sel_size - want[SIZE_W-1:0] - size_t'(HEADER_BYTES);
  assign need      = {2'b0, heap_top} + (SIZE_W+2)'(HEADER_BYTES) + {1'b0, want};

  // Merged sizes (wrap to the field width)
  size_t merge_next_size, merge_prev_size;
  assign merge_next_size = pa_size + size_t'(HEADER_BYTES) + pb_size;
  assign merge_prev_size = pb_size + size_t'(HEADER_BYTES) + pa_size;

  logic next_ok, prev_ok;
  assign next_ok = (mi_up < seg_count) && pb_free;
  assign prev_ok = (pick_idx != '0) && pb_free;

  // Cell command
  always_comb begin
    cmd       = '0;
    cmd.shift = SH_NONE;
    unique case (state)
      S_DEC: begin
        if (action == ACT_ALLOC) begin
          if (sel_found) begin
            cmd.we    = 1'b1;
            cmd.widx  = sel_idx;
            cmd.wsize = do_split ? want[SIZE_W-1:0] : sel_size;
            cmd.wfree = 1'b0;
            if (do_split) begin
              cmd.shift = SH_INSERT;
              cmd.sidx  = sel_up[IDX_W-1:0];
              cmd.ssize = rest;
              cmd.sfree = 1'b1;
            end
          end else if (seg_count < cnt_t'(MAX_SEGMENTS)
                       && need <= {2'b0, heap_limit}) begin
            cmd.we    = 1'b1;
            cmd.widx  = seg_count[IDX_W-1:0];
            cmd.wsize = want[SIZE_W-1:0];
            cmd.wfree = 1'b0;
          end
        end
      end
      S_MNEXT: begin
        cmd.we    = 1'b1;
        cmd.widx  = pick_idx;
        cmd.wsize = next_ok ? merge_next_size : pa_size;
        cmd.wfree = 1'b1;
        if (next_ok) begin
          cmd.shift = SH_DELETE;
          cmd.sidx  = mi_up[IDX_W-1:0];
        end
      end
      S_MPREV: begin
        if (prev_ok) begin
          cmd.we    = 1'b1;
          cmd.widx  = pb_idx;
          cmd.wsize = merge_prev_size;
          cmd.wfree = 1'b1;
          cmd.shift = SH_DELETE;
          cmd.sidx  = pick_idx;
        end
      end
      default: cmd.we = 1'b0;
    endcase
  end

  assign req.ready = (state == S_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode   <= FIT_FIRST;
      heap_limit <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIT_MODE:   fit_mode   <= fit_t'(cfg_data[1:0]);
        REG_HEAP_LIMIT: heap_limit <= cfg_data;
        default:        heap_limit <= heap_limit;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      seg_count   <= '0;
      heap_top    <= '0;
      rover       <= '0;
      rover_valid <= 1'b0;
      rsp.valid   <= 1'b0;
      found       <= 1'b0;
      found_hi    <= 1'b0;
    end else begin
      // Drop a taken beat; the response state reloads the register itself
      if (rsp.valid && rsp.ready && state != S_RESP) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            action     <= req.action;
            want       <= ({1'b0, req.request_size} + (SIZE_W+1)'(3))
                          & ~(SIZE_W+1)'(3);
            baddr      <= req.block_address;
            scan_idx   <= '0;
            acc        <= ACC_W'(HEADER_BYTES);
            found      <= 1'b0;
            found_hi   <= 1'b0;
            res_addr   <= '0;
            res_split  <= 1'b0;
            res_merges <= '0;
            // Next fit starts just past the rover, or at the first segment
            if (rover_valid && ({1'b0, rover} + cnt_t'(1)) < seg_count) begin
              start <= {1'b0, rover} + cnt_t'(1);
            end else begin
              start <= '0;
            end
            if (req.action == ACT_ALLOC && req.request_size == '0) begin
              res_status <= ST_ZERO;
              state      <= S_RESP;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_idx == seg_count) begin
            state <= S_DEC;
          end else begin
            if (take_main) begin
              found     <= 1'b1;
              pick_idx  <= scan_idx[IDX_W-1:0];
              pick_size <= pa_size;
              pick_addr <= acc;
            end
            if (take_hi) begin
              found_hi <= 1'b1;
              hi_idx   <= scan_idx[IDX_W-1:0];
              hi_size  <= pa_size;
              hi_addr  <= acc;
            end
            acc      <= acc + ACC_W'(HEADER_BYTES) + {{(ACC_W-SIZE_W){1'b0}}, pa_size};
            scan_idx <= scan_idx + cnt_t'(1);
          end
        end
        S_DEC: begin
          if (action == ACT_FREE) begin
            if (found) begin
              state <= S_MNEXT;
            end else begin
              res_status <= ST_UNKNOWN;
              state      <= S_RESP;
            end
          end else begin
            state <= S_RESP;
            if (sel_found) begin
              res_status <= ST_REUSED;
              res_addr   <= sel_addr[ADDR_BITS-1:0];
              res_split  <= do_split;
              if (fit_mode == FIT_NEXT) begin
                rover       <= sel_idx;
                rover_valid <= 1'b1;
              end else if (do_split && rover_valid && {1'b0, rover} >= sel_up) begin
                rover <= rover + idx_t'(1);
              end
              if (do_split) begin
                seg_count <= seg_count + cnt_t'(1);
              end
            end else if (seg_count < cnt_t'(MAX_SEGMENTS)
                         && need <= {2'b0, heap_limit}) begin
              res_status <= ST_GROWN;
              res_addr   <= heap_top + size_t'(HEADER_BYTES);
              seg_count  <= seg_count + cnt_t'(1);
              heap_top   <= need[SIZE_W-1:0];
            end else begin
              res_status <= ST_NOSPACE;
            end
          end
        end
        S_MNEXT: begin
          // Absorb a free successor
          if (next_ok) begin
            seg_count  <= seg_count - cnt_t'(1);
            res_merges <= 2'd1;
            if (rover_valid && {1'b0, rover} >= mi_up) begin
              rover <= rover - idx_t'(1);
            end
          end
          state <= S_MPREV;
        end
        S_MPREV: begin
          // Fold into a free predecessor; the rover follows it
          if (prev_ok) begin
            seg_count  <= seg_count - cnt_t'(1);
            res_merges <= res_merges + 2'd1;
            if (rover_valid && rover >= pick_idx) begin
              rover <= rover - idx_t'(1);
            end
          end
          res_status <= ST_FREED;
          state      <= S_RESP;
        end
        S_RESP: begin
          // Hold until the output register is free
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.data_address <= res_addr;
            rsp.status       <= res_status;
            rsp.split_done   <= res_split;
            rsp.merges       <= res_merges;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sim/tb_heap_segment_allocator.sv -----
// Self-checking testbench of the heap segment allocator: directed and random beats.
module tb_heap_segment_allocator;
  import hsa_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_FIT_MODE;
  logic [SIZE_W-1:0] cfg_data = '0;

  hsa_req_if req ();
  hsa_rsp_if rsp ();

  heap_segment_allocator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One expected response beat.
  typedef struct {
    logic [ADDR_BITS-1:0] data_address;
    status_t              status;
    logic                 split_done;
    logic [1:0]           merges;
  } outcome_t;

  // Shadow copy of the segment table, the heap top, the rover and the registers.
  int unsigned seg_bytes[MAX_SEGMENTS];
  bit          seg_free[MAX_SEGMENTS];
  int          seg_total;
  longint      heap_top;
  int          rover;
  bit          rover_set;
  fit_t        fit_mode;
  int unsigned heap_limit;

  outcome_t pending_outcomes[$];
  int unsigned live_addrs[$];

  int  mismatches;
  int  beats_sent;
  int  beats_checked;
  int  idle_cycles;
  bit  quiet_tail;
  bit  timed_out;

  localparam int WATCHDOG_LIMIT = 20000;

  function automatic longint data_addr_of(int idx);
    longint a = 0;
    for (int k = 0; k < idx; k++) a += HEADER_BYTES + seg_bytes[k];
    return a + HEADER_BYTES;
  endfunction

  function automatic void open_slot(int j, int unsigned bytes, bit fr);
    for (int k = seg_total; k > j; k--) begin
      seg_bytes[k] = seg_bytes[k-1];
      seg_free[k]  = seg_free[k-1];
    end
    seg_bytes[j] = bytes;
    seg_free[j]  = fr;
    seg_total++;
    if (rover_set && rover >= j) rover++;
  endfunction

  function automatic void close_slot(int j);
    for (int k = j; k < seg_total - 1; k++) begin
      seg_bytes[k] = seg_bytes[k+1];
      seg_free[k]  = seg_free[k+1];
    end
    seg_total--;
    if (rover_set && rover >= j) begin
      if (rover > 0) rover--;
      else rover_set = 1'b0;
    end
  endfunction

  function automatic int pick_segment(longint need);
    int pick = -1;
    int i;
    if (seg_total == 0) return -1;
    if (fit_mode == FIT_NEXT) begin
      i = rover_set ? rover + 1 : 0;
      if (i >= seg_total) i = 0;
      for (int n = 0; n < seg_total; n++) begin
        if (seg_free[i] && seg_bytes[i] >= need) return i;
        i++;
        if (i >= seg_total) i = 0;
      end
      return -1;
    end
    for (i = 0; i < seg_total; i++) begin
      if (!(seg_free[i] && seg_bytes[i] >= need)) continue;
      if (fit_mode == FIT_FIRST) return i;
      if (pick < 0 || (fit_mode == FIT_BEST && seg_bytes[i] < seg_bytes[pick]) ||
          (fit_mode == FIT_WORST && seg_bytes[i] > seg_bytes[pick]))
        pick = i;
    end
    return pick;
  endfunction

  // Advance the shadow heap by one request and return the response it causes.
  function automatic outcome_t heap_outcome(logic act, int unsigned req_bytes,
                                            int unsigned addr);
    outcome_t o;
    longint need, grown;
    int f, hit;
    longint a;
    o.data_address = '0;
    o.status       = ST_REUSED;
    o.split_done   = 1'b0;
    o.merges       = 2'd0;
    if (act == ACT_ALLOC) begin
      if (req_bytes == 0) begin
        o.status = ST_ZERO;
        return o;
      end
      need = (longint'(req_bytes) + 3) & ~longint'(3);
      f = pick_segment(need);
      if (f >= 0) begin
        if (seg_bytes[f] > need + HEADER_BYTES + 4 && seg_total < MAX_SEGMENTS) begin
          open_slot(f + 1, seg_bytes[f] - int'(need) - HEADER_BYTES, 1'b1);
          seg_bytes[f] = int'(need);
          o.split_done = 1'b1;
        end
        seg_free[f] = 1'b0;
        if (fit_mode == FIT_NEXT) begin
          rover = f;
          rover_set = 1'b1;
        end
        o.data_address = ADDR_BITS'(data_addr_of(f));
      end else begin
        grown = heap_top + HEADER_BYTES + need;
        if (seg_total >= MAX_SEGMENTS || grown > heap_limit) begin
          o.status = ST_NOSPACE;
        end else begin
          o.data_address = ADDR_BITS'(heap_top + HEADER_BYTES);
          seg_bytes[seg_total] = int'(need);
          seg_free[seg_total] = 1'b0;
          seg_total++;
          heap_top = grown;
          o.status = ST_GROWN;
        end
      end
    end else begin
      hit = -1;
      a = HEADER_BYTES;
      for (int i = 0; i < seg_total; i++) begin
        if (a == addr && !seg_free[i]) begin
          hit = i;
          break;
        end
        a += HEADER_BYTES + seg_bytes[i];
      end
      if (hit < 0) begin
        o.status = ST_UNKNOWN;
        return o;
      end
      seg_free[hit] = 1'b1;
      // Absorb a free successor first, then fold into a free predecessor.
      if (hit + 1 < seg_total && seg_free[hit+1]) begin
        seg_bytes[hit] = (seg_bytes[hit] + HEADER_BYTES + seg_bytes[hit+1]) & 24'hFFFFFF;
        close_slot(hit + 1);
        o.merges++;
      end
      if (hit > 0 && seg_free[hit-1]) begin
        seg_bytes[hit-1] = (seg_bytes[hit-1] + HEADER_BYTES + seg_bytes[hit]) & 24'hFFFFFF;
        close_slot(hit);
        o.merges++;
      end
      o.status = ST_FREED;
    end
    return o;
  endfunction

  // Write one register; only called while the block is idle.
  task automatic write_reg(logic idx, int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[SIZE_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_FIT_MODE) fit_mode = fit_t'(value[1:0]);
    else heap_limit = value & 24'hFFFFFF;
  endtask

  // Offer one beat, hold it until accepted, and record what it should return.
  // Valid stays up after acceptance; an idle gap or a drain lowers it.
  task automatic send_request(logic act, int unsigned req_bytes, int unsigned addr);
    outcome_t o;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req.valid         <= 1'b1;
    req.action        <= act;
    req.request_size  <= req_bytes[SIZE_W-1:0];
    req.block_address <= addr[SIZE_W-1:0];
    do @(posedge clk); while (!req.ready);
    o = heap_outcome(act, req_bytes & 32'h00FFFFFF, addr & 32'h00FFFFFF);
    pending_outcomes.push_back(o);
    if (act == ACT_ALLOC && (o.status == ST_REUSED || o.status == ST_GROWN))
      live_addrs.push_back({8'h00, o.data_address});
    beats_sent++;
  endtask

  task automatic alloc_bytes(int unsigned n);
    send_request(ACT_ALLOC, n, $urandom());
  endtask

  // Free a live block picked at random, or a stray address now and then.
  task automatic free_some(bit stray);
    int k;
    if (stray || live_addrs.size() == 0) begin
      send_request(ACT_FREE, $urandom(), $urandom() & 24'hFFFFFF);
      return;
    end
    k = $urandom_range(0, live_addrs.size() - 1);
    send_request(ACT_FREE, $urandom(), live_addrs[k]);
    live_addrs.delete(k);
  endtask

  // Hold until every outstanding response has drained, then let the block settle.
  task automatic drain();
    req.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Response checker: compare each beat against the oldest expectation.
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      beats_checked++;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response beat status=%0d", rsp.status);
      end else begin
        e = pending_outcomes.pop_front();
        if (rsp.data_address !== e.data_address || rsp.status !== e.status ||
            rsp.split_done !== e.split_done || rsp.merges !== e.merges) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp addr=%h st=%0d split=%0d mg=%0d, ",
                      "got addr=%h st=%0d split=%0d mg=%0d"},
                     e.data_address, e.status, e.split_done, e.merges,
                     rsp.data_address, rsp.status, rsp.split_done, rsp.merges);
        end
      end
    end
  end

  // Receiver stalls come in bursts; the quiet tail drops them.
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet_tail) begin
      rsp.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp.ready  <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 12);
      rsp.ready  <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Watchdog: count cycles with no accepted beat on either channel.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("FAIL heap_segment_allocator");
        $finish;
      end
    end
  end

  // Zero size, huge size, odd sizes, unknown and double frees, merges both ways.
  task automatic test_directed();
    int unsigned a0, a1, a2;
    alloc_bytes(0);
    alloc_bytes(24'hFFFFFF);
    alloc_bytes(1);
    alloc_bytes(5);
    alloc_bytes(200);
    alloc_bytes(3);
    a0 = live_addrs[0];
    a1 = live_addrs[1];
    a2 = live_addrs[2];
    send_request(ACT_FREE, 0, 0);
    send_request(ACT_FREE, 0, 24'hFFFFFF);
    send_request(ACT_FREE, 0, a0 + 4);
    send_request(ACT_FREE, 0, a0);
    send_request(ACT_FREE, 0, a0);
    send_request(ACT_FREE, 0, a2);
    send_request(ACT_FREE, 0, a1);
    live_addrs.delete(0);
    live_addrs.delete(0);
    live_addrs.delete(0);
    alloc_bytes(8);
    alloc_bytes(100);
    alloc_bytes(24'h00FFFD);
    drain();
  endtask

  // Heap limit at zero, just above the heap top, then back at its maximum.
  task automatic test_heap_limit();
    write_reg(REG_HEAP_LIMIT, 0);
    alloc_bytes(24'h100000);
    alloc_bytes(1);
    drain();
    write_reg(REG_HEAP_LIMIT, 32'(heap_top + 40));
    alloc_bytes(8);
    alloc_bytes(12);
    drain();
    write_reg(REG_HEAP_LIMIT, 24'hFFFFFF);
  endtask

  // Fill the table to its capacity so grows fail and splits are skipped.
  task automatic test_full_table();
    while (seg_total < MAX_SEGMENTS) begin
      alloc_bytes($urandom_range(1, 64));
      drain();
    end
    alloc_bytes(4);
    free_some(1'b0);
    free_some(1'b0);
    drain();
    alloc_bytes(4);
    while (live_addrs.size() > 0) free_some(1'b0);
    drain();
  endtask

  // Random mix per fit mode: mostly live frees and modest sizes, some noise.
  task automatic test_random_mix(fit_t mode, int beats);
    int r;
    write_reg(REG_FIT_MODE, mode);
    for (int n = 0; n < beats; n++) begin
      r = $urandom_range(0, 99);
      if (r < 50) alloc_bytes($urandom_range(1, 600));
      else if (r < 53) alloc_bytes($urandom());
      else if (r < 56) alloc_bytes($urandom_range(0, 3));
      else if (r < 93) free_some(1'b0);
      else free_some(1'b1);
      // At least once, pause the sender until nothing is owed.
      if (n == beats / 2) drain();
    end
    drain();
  endtask

  initial begin
    req.valid = 1'b0;
    req.action = ACT_ALLOC;
    req.request_size = '0;
    req.block_address = '0;
    rsp.ready = 1'b0;
    mismatches = 0;
    beats_sent = 0;
    beats_checked = 0;
    idle_cycles = 0;
    quiet_tail = 1'b0;
    seg_total = 0;
    heap_top = 0;
    rover = 0;
    rover_set = 1'b0;
    fit_mode = FIT_FIRST;
    heap_limit = 24'hFFFFFF;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_heap_limit();
    test_full_table();
    test_random_mix(FIT_BEST, 180);
    test_random_mix(FIT_WORST, 180);
    test_random_mix(FIT_NEXT, 180);
    test_random_mix(FIT_FIRST, 180);
    quiet_tail = 1'b1;
    test_random_mix(FIT_NEXT, 100);
    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d requests over all four fit modes, limit extremes and a full table",
             beats_sent);
    $display("%0d responses checked, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("PASS heap_segment_allocator");
    end else begin
      $display("FAIL heap_segment_allocator");
    end
    $finish;
  end

endmodule
